>>> hdl/bir_pkg.sv
package bir_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 8;
    localparam int CFG_W   = 9;
    localparam int IDX_W   = 4;
    localparam int FRAC_W  = 15;
    localparam int WGT_W   = FRAC_W + 1;

    // (2i+1)*s, the divisor 2t and the full quotient (offset bits plus Q15 fraction)
    localparam int NUM_W = COORD_W + 1 + CFG_W;
    localparam int LIM_W = NUM_W + 1;
    localparam int DEN_W = CFG_W + 1;
    localparam int QB    = CFG_W + FRAC_W;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;

    localparam logic [IDX_W-1:0] REG_SRC_W = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_SRC_H = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_TGT_W = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_TGT_H = IDX_W'(3);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

endpackage

>>> hdl/bir_ram.sv
module bir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/bir_div.sv
module bir_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bir_pkg::t_div_req     i_req,
    output logic                  o_done,
    output logic [bir_pkg::QB-1:0] o_quo
);
    import bir_pkg::*;

    localparam int CNT_W = $clog2(QB + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QB-1:0]    r_sh;
    logic [QB-1:0]    r_quo;
    logic [DEN_W:0]   trial;
    logic             fit;

    // restoring division of {num, 15 zero bits} by den, one quotient bit per cycle
    assign trial = {r_rem, r_sh[QB-1]};
    assign fit   = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= CNT_W'(QB);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - CNT_W'(1);
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // upper part of the dividend is already below the divisor
            r_rem <= DEN_W'(i_req.num >> CFG_W);
            r_sh  <= {i_req.num[CFG_W-1:0], FRAC_W'(0)};
            r_den <= i_req.den;
        end else if (r_cnt != '0) begin
            r_rem <= fit ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            r_sh  <= {r_sh[QB-2:0], 1'b0};
            r_quo <= {r_quo[QB-2:0], fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> hdl/bilinear_image_resize.sv
// Write item: stored in the cycle it is accepted if inside the source size, no result; one write per cycle while idle.
// Read item: result registered at the output; no new item is taken until the result is loaded there.
// The pace of a read is set by two 24-step radix-2 dividers (one per axis, in parallel)
// plus four reads through the single read port of the frame store.
// A read outside the target size skips the dividers and the fetch and returns its error result.
// Reset (synchronous, active low) sets all sizes to 256 and clears control; store is not cleared.
module bilinear_image_resize (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic [bir_pkg::COORD_W-1:0]   i_coord_x,
    input  logic [bir_pkg::COORD_W-1:0]   i_coord_y,
    input  logic [bir_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bir_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                          o_range_error,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bir_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [bir_pkg::CFG_W-1:0]     i_cfg_data
);
    import bir_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_MAP   = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_FETCH = 8'b0001_0000,
        S_VBL   = 8'b0010_0000,
        S_HBL   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    function automatic logic [CFG_W-1:0] f_clamp(input logic [CFG_W-1:0] v, input int hi);
        logic [CFG_W-1:0] res;
        res = v;
        if (v < CFG_W'(2)) begin
            res = CFG_W'(2);
        end else if (int'(v) > hi) begin
            res = CFG_W'(hi);
        end
        return res;
    endfunction

    // a + round((b - a) * w / 2^15), same as the weighted sum of a and b
    function automatic logic [PIX_W-1:0] f_blend(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b,
                                                 input logic [WGT_W-1:0] w);
        logic signed [PIX_W:0]   diff;
        logic signed [25:0]      prod;
        logic signed [25:0]      rnd;
        logic signed [PIX_W+1:0] step;
        logic signed [PIX_W+1:0] sum;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = 26'(diff) * 26'($signed({1'b0, w}));
        rnd  = prod + 26'sd16384;
        step = rnd[24:15];
        sum  = $signed({2'b00, a}) + step;
        return sum[PIX_W-1:0];
    endfunction

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_src_w, r_src_h, r_tgt_w, r_tgt_h;
    logic [CFG_W-1:0] sw_eff, sh_eff;
    logic [DEN_W-1:0] sw2m1, sh2m1;

    logic [COORD_W-1:0] r_cx, r_cy;
    logic               r_err;
    logic [NUM_W-1:0]   r_numx, r_numy;
    logic [LIM_W-1:0]   r_limx, r_limy;
    logic               r_lox, r_hix, r_loy, r_hiy;
    logic [CFG_W-1:0]   r_ox, r_oy;
    logic [WGT_W-1:0]   r_wx, r_wy;
    logic [1:0]         r_rd_cnt;
    logic [1:0]         tap_idx;
    logic [PIX_W-1:0]   r_tap [3];
    logic [PIX_W-1:0]   r_left, r_right;
    logic [PIX_W-1:0]   r_res_pix;
    logic               r_res_err;

    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_pix;
    logic               r_out_err;

    logic               in_accept;
    logic               out_load;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [PIX_W-1:0]   ram_rdata;
    logic [XW-1:0]      rd_col;
    logic [YW-1:0]      rd_row;

    t_div_req           div_req_x, div_req_y;
    logic               div_x_done, div_y_done;
    logic [QB-1:0]      quo_x, quo_y;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_accept   = i_in_valid & o_in_ready;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    assign sw_eff = f_clamp(r_src_w, MAX_WIDTH);
    assign sh_eff = f_clamp(r_src_h, MAX_HEIGHT);
    assign sw2m1  = {sw_eff, 1'b0} - DEN_W'(1);
    assign sh2m1  = {sh_eff, 1'b0} - DEN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= CFG_W'(256);
            r_src_h <= CFG_W'(256);
            r_tgt_w <= CFG_W'(256);
            r_tgt_h <= CFG_W'(256);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SRC_W: r_src_w <= i_cfg_data;
                REG_SRC_H: r_src_h <= i_cfg_data;
                REG_TGT_W: r_tgt_w <= i_cfg_data;
                REG_TGT_H: r_tgt_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame store: writes only while idle, read data used only while fetching and in the vertical blend
    assign ram_we    = in_accept && (i_opcode == OP_WRITE)
                       && ({1'b0, i_coord_x} < sw_eff) && ({1'b0, i_coord_y} < sh_eff);
    assign ram_waddr = {YW'(i_coord_y), XW'(i_coord_x)};
    assign rd_col    = XW'(r_ox + CFG_W'(r_rd_cnt[1]));
    assign rd_row    = YW'(r_oy + CFG_W'(r_rd_cnt[0]));
    assign ram_raddr = {rd_row, rd_col};

    bir_ram #(
        .WIDTH(PIX_W),
        .DEPTH(2 ** AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_pixel_in),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        div_req_x.start = (r_state == S_MAP) && !r_err;
        div_req_x.num   = NUM_W'(r_numx - NUM_W'(r_tgt_w));
        div_req_x.den   = {r_tgt_w, 1'b0};
        div_req_y.start = (r_state == S_MAP) && !r_err;
        div_req_y.num   = NUM_W'(r_numy - NUM_W'(r_tgt_h));
        div_req_y.den   = {r_tgt_h, 1'b0};
    end

    bir_div u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req_x),
        .o_done (div_x_done),
        .o_quo  (quo_x)
    );

    bir_div u_div_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req_y),
        .o_done (div_y_done),
        .o_quo  (quo_y)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_accept && (i_opcode == OP_READ)) n_state = S_MUL;
            S_MUL:   n_state = S_MAP;
            S_MAP:   n_state = r_err ? S_OUT : S_DIV;
            S_DIV:   if (div_x_done) n_state = S_FETCH;
            S_FETCH: if (r_rd_cnt == 2'd3) n_state = S_VBL;
            S_VBL:   n_state = S_HBL;
            S_HBL:   n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_cnt    <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FETCH) begin
                r_rd_cnt <= r_rd_cnt + 2'd1;
            end else begin
                r_rd_cnt <= 2'd0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign tap_idx = r_rd_cnt - 2'd1;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cx <= i_coord_x;
            r_cy <= i_coord_y;
        end
        if (r_state == S_MUL) begin
            r_err  <= ({1'b0, r_cx} >= r_tgt_w) || ({1'b0, r_cy} >= r_tgt_h);
            r_numx <= NUM_W'({r_cx, 1'b1}) * NUM_W'(sw_eff);
            r_numy <= NUM_W'({r_cy, 1'b1}) * NUM_W'(sh_eff);
            r_limx <= LIM_W'(sw2m1) * LIM_W'(r_tgt_w);
            r_limy <= LIM_W'(sh2m1) * LIM_W'(r_tgt_h);
        end
        if (r_state == S_MAP) begin
            r_lox     <= (r_numx <= NUM_W'(r_tgt_w));
            r_loy     <= (r_numy <= NUM_W'(r_tgt_h));
            r_hix     <= ({1'b0, r_numx} >= r_limx);
            r_hiy     <= ({1'b0, r_numy} >= r_limy);
            r_res_pix <= '0;
            r_res_err <= 1'b1;
        end
        if (r_state == S_DIV) begin
            // clamp to the first or last source center, else take the quotient
            if (r_lox) begin
                r_ox <= '0;
                r_wx <= '0;
            end else if (r_hix) begin
                r_ox <= sw_eff - CFG_W'(2);
                r_wx <= WGT_W'(32768);
            end else begin
                r_ox <= quo_x[QB-1:FRAC_W];
                r_wx <= {1'b0, quo_x[FRAC_W-1:0]};
            end
            if (r_loy) begin
                r_oy <= '0;
                r_wy <= '0;
            end else if (r_hiy) begin
                r_oy <= sh_eff - CFG_W'(2);
                r_wy <= WGT_W'(32768);
            end else begin
                r_oy <= quo_y[QB-1:FRAC_W];
                r_wy <= {1'b0, quo_y[FRAC_W-1:0]};
            end
        end
        if ((r_state == S_FETCH) && (r_rd_cnt != 2'd0)) begin
            r_tap[tap_idx] <= ram_rdata;
        end
        if (r_state == S_VBL) begin
            r_left  <= f_blend(r_tap[0], r_tap[1], r_wy);
            r_right <= f_blend(r_tap[2], ram_rdata, r_wy);
        end
        if (r_state == S_HBL) begin
            r_res_pix <= f_blend(r_left, r_right, r_wx);
            r_res_err <= 1'b0;
        end
        if (out_load) begin
            r_out_pix <= r_res_pix;
            r_out_err <= r_res_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_out   = r_out_pix;
    assign o_range_error = r_out_err;

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_x_done == div_y_done)
        else $error("axis dividers out of step");

    a_store_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE))
        else $error("frame store written outside idle");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result loaded without a finished read");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_error) |-> (o_pixel_out == '0))
        else $error("range error with nonzero pixel");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_x_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

endmodule
